/* design/dphf_pkg.sv */
// ----------------------------------------------------------------------------
// dphf_pkg
// Shared types and constants for the dual pressure health and fallback block.
// ----------------------------------------------------------------------------
package dphf_pkg;

  localparam int PRESS_W  = 24;
  localparam int DIFF_W   = PRESS_W + 1;
  localparam int CNT_W    = 16;
  localparam int AGE_W    = 32;
  localparam int CODE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_ENABLE  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] FAIL_DEBOUNCE_RST = 16'd5;
  localparam logic [CFG_DATA_W-1:0] STALE_LIMIT_RST   = 16'd500;

  // request kinds
  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // bus probe return codes
  localparam logic [CODE_W-1:0] PROBE_OK        = 8'd0;
  localparam logic [CODE_W-1:0] PROBE_ADDR_NACK = 8'd2;
  localparam logic [CODE_W-1:0] PROBE_DATA_NACK = 8'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_ADDR_NACK   = 3'd1,
    ERR_DATA_NACK   = 3'd2,
    ERR_OTHER       = 3'd3,
    ERR_UNAVAILABLE = 3'd4
  } err_code_t;

  typedef struct packed {
    logic                req_type;
    logic                mask_read_ok;
    logic [PRESS_W-1:0]  mask_pressure;
    logic                blower_read_ok;
    logic [PRESS_W-1:0]  blower_pressure;
    logic [CODE_W-1:0]   mask_probe_code;
    logic [CODE_W-1:0]   blower_probe_code;
  } req_t;

  typedef struct packed {
    logic                     healthy;
    logic                     both_live_ok;
    logic [PRESS_W-1:0]       mask_value;
    logic                     mask_valid;
    logic [PRESS_W-1:0]       blower_value;
    logic                     blower_valid;
    logic signed [DIFF_W-1:0] pressure_diff;
    logic                     diff_valid;
    logic [CNT_W-1:0]         mask_miss_count;
    logic [CNT_W-1:0]         blower_miss_count;
    err_code_t                mask_error;
    err_code_t                blower_error;
  } res_t;

  // per-sensor tracking state
  typedef struct packed {
    logic [PRESS_W-1:0] cache;
    logic               cache_valid;
    logic               live_ok;
    logic [CNT_W-1:0]   misses;
    err_code_t          last_error;
  } sens_state_t;

  function automatic err_code_t map_probe(input logic [CODE_W-1:0] code,
                                          input logic probe_en);
    err_code_t e;
    e = ERR_OTHER;
    if (!probe_en) begin
      e = ERR_UNAVAILABLE;
    end else begin
      case (code)
        PROBE_OK:        e = ERR_OK;
        PROBE_ADDR_NACK: e = ERR_ADDR_NACK;
        PROBE_DATA_NACK: e = ERR_DATA_NACK;
        default:         e = ERR_OTHER;
      endcase
    end
    return e;
  endfunction

endpackage

/* design/dphf_req_if.sv */
// ----------------------------------------------------------------------------
// dphf_req_if
// Request channel: sensor read results and millisecond ticks.
// ----------------------------------------------------------------------------
interface dphf_req_if;
  import dphf_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/dphf_res_if.sv */
// ----------------------------------------------------------------------------
// dphf_res_if
// Result channel: health, fallback pressures, difference and error status.
// ----------------------------------------------------------------------------
interface dphf_res_if;
  import dphf_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/dual_pressure_health_fallback.sv */
// ----------------------------------------------------------------------------
// dual_pressure_health_fallback
// Mask and blower pressure health monitor with per-sensor fallback values.
// ----------------------------------------------------------------------------
// Each request (a sensor read result or a one millisecond tick) gives one
// result in the next cycle from the result register; a request can be taken
// every cycle while the result side keeps up, since the whole update is one
// pass of counters, compares and a 25-bit subtract. Configuration is written
// through cfg_we/cfg_index/cfg_data, by the user only while idle (unchecked).
module dual_pressure_health_fallback (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dphf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dphf_pkg::CFG_DATA_W-1:0]   cfg_data,
  dphf_req_if.sink                          req,
  dphf_res_if.source                        res
);
  import dphf_pkg::*;

  logic [CNT_W-1:0]  fail_limit;
  logic [CNT_W-1:0]  stale_limit;
  logic              probe_en;

  logic [CNT_W-1:0]  bad_streak, bad_streak_next;
  logic [AGE_W-1:0]  ms_since_good, ms_since_good_next;

  logic              res_valid;
  res_t              res_data, res_data_next;

  logic              take, read_take, tick_take;
  sens_state_t       mask_next, blower_next;
  logic              both_next;
  logic [PRESS_W-1:0] mv, bv;

  assign req.ready = !res_valid || res.ready;
  assign take      = req.valid && req.ready;
  assign read_take = take && (req.data.req_type == REQ_READ);
  assign tick_take = take && (req.data.req_type == REQ_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit  <= FAIL_DEBOUNCE_RST;
      stale_limit <= STALE_LIMIT_RST;
      probe_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAIL_DEBOUNCE: fail_limit  <= cfg_data;
        CFG_STALE_LIMIT:   stale_limit <= cfg_data;
        CFG_PROBE_ENABLE:  probe_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dphf_sensor u_mask (
    .clk        (clk),
    .rst        (rst),
    .upd        (read_take),
    .read_ok    (req.data.mask_read_ok),
    .pressure   (req.data.mask_pressure),
    .probe_code (req.data.mask_probe_code),
    .probe_en   (probe_en),
    .state_next (mask_next)
  );

  dphf_sensor u_blower (
    .clk        (clk),
    .rst        (rst),
    .upd        (read_take),
    .read_ok    (req.data.blower_read_ok),
    .pressure   (req.data.blower_pressure),
    .probe_code (req.data.blower_probe_code),
    .probe_en   (probe_en),
    .state_next (blower_next)
  );

  assign both_next = mask_next.live_ok && blower_next.live_ok;

  always_comb begin
    ms_since_good_next = ms_since_good;
    bad_streak_next    = bad_streak;
    if (tick_take) begin
      if (ms_since_good != AGE_MAX) begin
        ms_since_good_next = ms_since_good + 1'b1;
      end
    end else if (read_take) begin
      if (mask_next.live_ok || blower_next.live_ok) begin
        ms_since_good_next = '0;
      end
      if (both_next) begin
        bad_streak_next = '0;
      end else if (bad_streak != CNT_MAX) begin
        bad_streak_next = bad_streak + 1'b1;
      end
    end
  end

  always_comb begin
    mv = mask_next.cache_valid ? mask_next.cache : '0;
    bv = blower_next.cache_valid ? blower_next.cache : '0;
    res_data_next.healthy = both_next ||
      ((bad_streak_next < fail_limit) &&
       (ms_since_good_next < {{(AGE_W-CNT_W){1'b0}}, stale_limit}));
    res_data_next.both_live_ok = both_next;
    res_data_next.mask_value   = mv;
    res_data_next.mask_valid   = mask_next.cache_valid;
    res_data_next.blower_value = bv;
    res_data_next.blower_valid = blower_next.cache_valid;
    res_data_next.diff_valid   = mask_next.cache_valid && blower_next.cache_valid;
    // wraps to 25 bits, zero when either side has no value
    res_data_next.pressure_diff = res_data_next.diff_valid ?
      ({1'b0, bv} - {1'b0, mv}) : '0;
    res_data_next.mask_miss_count   = mask_next.misses;
    res_data_next.blower_miss_count = blower_next.misses;
    res_data_next.mask_error        = mask_next.last_error;
    res_data_next.blower_error      = blower_next.last_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_streak    <= '0;
      ms_since_good <= '0;
      res_valid     <= 1'b0;
    end else begin
      bad_streak    <= bad_streak_next;
      ms_since_good <= ms_since_good_next;
      if (take) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (take) begin
      res_data <= res_data_next;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

  a_both_healthy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.both_live_ok |-> res_data.healthy)
    else $error("both sensors live but not healthy");

  a_diff_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.diff_valid == (res_data.mask_valid && res_data.blower_valid)))
    else $error("difference valid does not match value valids");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |-> !req.ready)
    else $error("request taken while result stalled");

  a_read_resets_age: assert property (@(posedge clk) disable iff (rst)
    read_take && (req.data.mask_read_ok || req.data.blower_read_ok) |=>
      ms_since_good == '0)
    else $error("good read did not clear age");
endmodule

/* design/dphf_sensor.sv */
// ----------------------------------------------------------------------------
// dphf_sensor
// One sensor's cache, live flag, saturating miss counter and last error.
// ----------------------------------------------------------------------------
module dphf_sensor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           upd,
  input  logic                           read_ok,
  input  logic [dphf_pkg::PRESS_W-1:0]   pressure,
  input  logic [dphf_pkg::CODE_W-1:0]    probe_code,
  input  logic                           probe_en,
  output dphf_pkg::sens_state_t          state_next
);
  import dphf_pkg::*;

  sens_state_t state;

  always_comb begin
    state_next = state;
    if (upd) begin
      if (read_ok) begin
        state_next.cache       = pressure;
        state_next.cache_valid = 1'b1;
        state_next.live_ok     = 1'b1;
        state_next.misses      = '0;
        state_next.last_error  = ERR_OK;
      end else begin
        state_next.live_ok    = 1'b0;
        state_next.last_error = map_probe(probe_code, probe_en);
        if (state.misses != CNT_MAX) begin
          state_next.misses = state.misses + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.cache_valid <= 1'b0;
      state.live_ok     <= 1'b0;
      state.misses      <= '0;
      state.last_error  <= ERR_OK;
    end else begin
      state.cache_valid <= state_next.cache_valid;
      state.live_ok     <= state_next.live_ok;
      state.misses      <= state_next.misses;
      state.last_error  <= state_next.last_error;
    end
    state.cache <= state_next.cache;
  end

  a_live_clears: assert property (@(posedge clk) disable iff (rst)
    state.live_ok |-> (state.misses == '0 && state.last_error == ERR_OK))
    else $error("live sensor with pending misses or error");

  a_live_fills_cache: assert property (@(posedge clk) disable iff (rst)
    state.live_ok |-> state.cache_valid)
    else $error("live sensor without cached value");

  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    upd && !read_ok && $past(!rst) |=> (state.misses != '0 && !state.live_ok))
    else $error("failed read did not count a miss");
endmodule
